@@ hw/rtl/lcdcd_pkg.sv @@
// shared types and constants of the lcd controller command decoder
// command codes, decoded operation type and the item passed from front to back
// no dependencies
package lcdcd_pkg;

	localparam logic [7:0] CMD_PAGE_BASE  = 8'd176;
	localparam logic [7:0] CMD_COL_HIGH   = 8'h10;
	localparam logic [7:0] NIBBLE_MASK    = 8'h0F;
	localparam logic [7:0] CMD_RESET      = 8'hE2;
	localparam logic [7:0] CMD_NOP        = 8'hE3;
	localparam logic [7:0] CMD_VOLUME     = 8'h81;
	localparam logic [7:0] CMD_START_LINE = 8'h40;
	localparam logic [7:0] CMD_START_END  = 8'h80;
	localparam logic [7:0] CMD_DISPLAY    = 8'hAE;
	localparam logic [7:0] CMD_INVERSE    = 8'hA6;
	localparam logic [7:0] CMD_ALL_ON     = 8'hA4;
	localparam logic [7:0] CMD_BIAS       = 8'hA2;
	localparam logic [7:0] CMD_SEG        = 8'hA0;
	localparam logic [7:0] CMD_POWER      = 8'h28;
	localparam logic [7:0] CMD_POWER_END  = 8'h30;
	localparam logic [7:0] CMD_RATIO      = 8'h20;
	localparam logic [7:0] CMD_COM        = 8'hC0;
	localparam logic [7:0] PAIR_MASK      = 8'hFE;
	localparam logic [7:0] GROUP_MASK     = 8'hF0;

	localparam logic [5:0] VOLUME_RESET = 6'd32;

	// one-hot positions in status_flags
	localparam logic [5:0] FLAG_ON   = 6'h01;
	localparam logic [5:0] FLAG_INV  = 6'h02;
	localparam logic [5:0] FLAG_ALL  = 6'h04;
	localparam logic [5:0] FLAG_SEG  = 6'h08;
	localparam logic [5:0] FLAG_COM  = 6'h10;
	localparam logic [5:0] FLAG_BIAS = 6'h20;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [3:0] {
		OP_DATA,
		OP_RESET,
		OP_VOLUME,
		OP_NOP,
		OP_COL_LO,
		OP_COL_HI,
		OP_RATIO,
		OP_POWER,
		OP_START,
		OP_FLAG,
		OP_PAGE,
		OP_UNKNOWN
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] byte_val;
		logic [5:0] flag_mask;
		logic       flag_val;
	} item_t;

endpackage

@@ hw/rtl/lcd_controller_command_decoder.sv @@
// lcd controller command decoder: one byte in, one result item out
// an accepted byte is stored in the queue, then executed into the output register
// throughput: one item per cycle when not stalled, set by the back end execute stage
// a two-entry queue between front and back absorbs input while a result is stalled
// reset: arst_n clears addresses, flags, power, ratio and start line, sets contrast to 32
// uses lcdcd_pkg, lcdcd_front, lcdcd_queue, lcdcd_back
module lcd_controller_command_decoder #(
	parameter int PAGES   = 8,
	parameter int COLUMNS = 132
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  logic       is_data,
	input  logic [7:0] serial_byte,
	output logic       res_valid,
	input  logic       res_stall,
	output logic       ram_write,
	output logic [2:0] ram_page,
	output logic [7:0] ram_column,
	output logic [7:0] ram_data,
	output logic [5:0] status_flags,
	output logic [5:0] contrast_level,
	output logic [2:0] power_control,
	output logic [2:0] regulation_ratio,
	output logic [5:0] first_line,
	output logic       unknown_command
);
	import lcdcd_pkg::*;

	item_t front_item;
	item_t head_item;
	logic  q_full;
	logic  q_empty;
	logic  q_pop;

	assign cmd_stall = q_full;

	lcdcd_front u_front (
		.is_data     (is_data),
		.serial_byte (serial_byte),
		.item        (front_item)
	);

	lcdcd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_valid),
		.push_item (front_item),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (head_item)
	);

	lcdcd_back #(
		.PAGES   (PAGES),
		.COLUMNS (COLUMNS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_empty          (q_empty),
		.q_head           (head_item),
		.q_pop            (q_pop),
		.res_valid        (res_valid),
		.res_stall        (res_stall),
		.ram_write        (ram_write),
		.ram_page         (ram_page),
		.ram_column       (ram_column),
		.ram_data         (ram_data),
		.status_flags     (status_flags),
		.contrast_level   (contrast_level),
		.power_control    (power_control),
		.regulation_ratio (regulation_ratio),
		.first_line       (first_line),
		.unknown_command  (unknown_command)
	);

endmodule

@@ hw/rtl/lcdcd_front.sv @@
// front end: accepts a byte with its a0 flag and classifies it into an operation
// uses lcdcd_pkg; feeds lcdcd_queue
module lcdcd_front (
	input  logic             is_data,
	input  logic [7:0]       serial_byte,
	output lcdcd_pkg::item_t item
);
	import lcdcd_pkg::*;

	logic [7:0] pair;
	logic [7:0] group;

	assign pair  = serial_byte & PAIR_MASK;
	assign group = serial_byte & GROUP_MASK;

	always_comb begin
		item.op        = OP_UNKNOWN;
		item.byte_val  = serial_byte;
		item.flag_mask = '0;
		item.flag_val  = serial_byte[0];
		if (is_data) begin
			item.op = OP_DATA;
		end else if (serial_byte == CMD_RESET) begin
			item.op = OP_RESET;
		end else if (serial_byte == CMD_VOLUME) begin
			item.op = OP_VOLUME;
		end else if (serial_byte == CMD_NOP) begin
			item.op = OP_NOP;
		end else if (serial_byte < CMD_COL_HIGH) begin
			item.op = OP_COL_LO;
		end else if (serial_byte < CMD_RATIO) begin
			item.op = OP_COL_HI;
		end else if (serial_byte < CMD_POWER) begin
			item.op = OP_RATIO;
		end else if (serial_byte < CMD_POWER_END) begin
			item.op = OP_POWER;
		end else if (serial_byte >= CMD_START_LINE && serial_byte < CMD_START_END) begin
			item.op = OP_START;
		end else if (pair == CMD_SEG) begin
			item.op        = OP_FLAG;
			item.flag_mask = FLAG_SEG;
		end else if (pair == CMD_BIAS) begin
			item.op        = OP_FLAG;
			item.flag_mask = FLAG_BIAS;
		end else if (pair == CMD_ALL_ON) begin
			item.op        = OP_FLAG;
			item.flag_mask = FLAG_ALL;
		end else if (pair == CMD_INVERSE) begin
			item.op        = OP_FLAG;
			item.flag_mask = FLAG_INV;
		end else if (pair == CMD_DISPLAY) begin
			item.op        = OP_FLAG;
			item.flag_mask = FLAG_ON;
		end else if (group == CMD_PAGE_BASE) begin
			item.op = OP_PAGE;
		end else if (group == CMD_COM) begin
			// com direction comes from bit3, not bit0
			item.op        = OP_FLAG;
			item.flag_mask = FLAG_COM;
			item.flag_val  = serial_byte[3];
		end
	end

endmodule

@@ hw/rtl/lcdcd_queue.sv @@
// short fifo of classified items between front and back
// uses lcdcd_pkg
module lcdcd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  lcdcd_pkg::item_t push_item,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output lcdcd_pkg::item_t head
);
	import lcdcd_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	item_t            mem [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/lcdcd_back.sv @@
// back end: carries out classified items on the controller registers
// and holds the result item in an output register; uses lcdcd_pkg
module lcdcd_back #(
	parameter int PAGES   = 8,
	parameter int COLUMNS = 132
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  lcdcd_pkg::item_t q_head,
	output logic             q_pop,
	output logic             res_valid,
	input  logic             res_stall,
	output logic             ram_write,
	output logic [2:0]       ram_page,
	output logic [7:0]       ram_column,
	output logic [7:0]       ram_data,
	output logic [5:0]       status_flags,
	output logic [5:0]       contrast_level,
	output logic [2:0]       power_control,
	output logic [2:0]       regulation_ratio,
	output logic [5:0]       first_line,
	output logic             unknown_command
);
	import lcdcd_pkg::*;

	localparam logic [4:0] PAGE_LIMIT = 5'(PAGES);
	localparam logic [8:0] COL_LIMIT  = 9'(COLUMNS);

	// controller registers
	logic [3:0] page_q;
	logic [7:0] column_q;
	logic       vol_pending_q;
	logic [5:0] mode_q;
	logic [5:0] volume_q;
	logic [2:0] power_q;
	logic [2:0] ratio_q;
	logic [5:0] start_q;

	logic [3:0] page_d;
	logic [7:0] column_d;
	logic       vol_pending_d;
	logic [5:0] mode_d;
	logic [5:0] volume_d;
	logic [2:0] power_d;
	logic [2:0] ratio_d;
	logic [5:0] start_d;

	logic       wr_d;
	logic [2:0] pg_d;
	logic [7:0] col_d;
	logic [7:0] dat_d;
	logic       unk_d;

	logic       out_valid_q;
	logic       wr_q;
	logic [2:0] pg_q;
	logic [7:0] col_q;
	logic [7:0] dat_q;
	logic       unk_q;

	logic       col_in_range;
	logic       page_in_range;

	assign q_pop         = !q_empty && (!out_valid_q || !res_stall);
	assign col_in_range  = ({1'b0, column_q} < COL_LIMIT);
	assign page_in_range = ({1'b0, page_q} < PAGE_LIMIT);

	always_comb begin
		page_d        = page_q;
		column_d      = column_q;
		vol_pending_d = vol_pending_q;
		mode_d        = mode_q;
		volume_d      = volume_q;
		power_d       = power_q;
		ratio_d       = ratio_q;
		start_d       = start_q;
		wr_d          = 1'b0;
		pg_d          = '0;
		col_d         = '0;
		dat_d         = '0;
		unk_d         = 1'b0;
		if (q_head.op == OP_DATA) begin
			if (page_in_range && col_in_range) begin
				wr_d  = 1'b1;
				pg_d  = page_q[2:0];
				col_d = column_q;
				dat_d = q_head.byte_val;
			end
			// column stops advancing once it reaches or passes the limit, never wraps
			if (col_in_range) begin
				column_d = column_q + 8'd1;
			end
		end else if (vol_pending_q) begin
			// any command byte after the volume command is the volume value
			volume_d      = q_head.byte_val[5:0];
			vol_pending_d = 1'b0;
		end else begin
			case (q_head.op)
				OP_RESET: begin
					page_d        = '0;
					column_d      = '0;
					vol_pending_d = 1'b0;
					mode_d        = '0;
					volume_d      = VOLUME_RESET;
					power_d       = '0;
					ratio_d       = '0;
					start_d       = '0;
				end
				OP_VOLUME: vol_pending_d = 1'b1;
				OP_NOP: ;
				OP_COL_LO: column_d = {column_q[7:4], q_head.byte_val[3:0] & NIBBLE_MASK[3:0]};
				OP_COL_HI: column_d = {q_head.byte_val[3:0] & NIBBLE_MASK[3:0], column_q[3:0]};
				OP_RATIO: ratio_d = q_head.byte_val[2:0];
				OP_POWER: power_d = q_head.byte_val[2:0];
				OP_START: start_d = q_head.byte_val[5:0];
				OP_FLAG: begin
					if (q_head.flag_val) begin
						mode_d = mode_q | q_head.flag_mask;
					end else begin
						mode_d = mode_q & ~q_head.flag_mask;
					end
				end
				OP_PAGE: page_d = q_head.byte_val[3:0];
				default: unk_d = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q        <= '0;
			column_q      <= '0;
			vol_pending_q <= 1'b0;
			mode_q        <= '0;
			volume_q      <= VOLUME_RESET;
			power_q       <= '0;
			ratio_q       <= '0;
			start_q       <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (q_pop) begin
				page_q        <= page_d;
				column_q      <= column_d;
				vol_pending_q <= vol_pending_d;
				mode_q        <= mode_d;
				volume_q      <= volume_d;
				power_q       <= power_d;
				ratio_q       <= ratio_d;
				start_q       <= start_d;
				out_valid_q   <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, held while stalled
	always_ff @(posedge clk) begin
		if (q_pop) begin
			wr_q  <= wr_d;
			pg_q  <= pg_d;
			col_q <= col_d;
			dat_q <= dat_d;
			unk_q <= unk_d;
		end
	end

	assign res_valid        = out_valid_q;
	assign ram_write        = wr_q;
	assign ram_page         = pg_q;
	assign ram_column       = col_q;
	assign ram_data         = dat_q;
	assign unknown_command  = unk_q;
	// register fields show the values left after the item
	assign status_flags     = mode_q;
	assign contrast_level   = volume_q;
	assign power_control    = power_q;
	assign regulation_ratio = ratio_q;
	assign first_line       = start_q;

endmodule

@@ hw/rtl/lcdcd_checker.sv @@
// port-level checks for the lcd controller command decoder
// bound to lcd_controller_command_decoder; no other dependencies
module lcdcd_checker #(
	parameter int COLUMNS = 132
) (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_stall,
	input logic       ram_write,
	input logic [2:0] ram_page,
	input logic [7:0] ram_column,
	input logic [7:0] ram_data,
	input logic [5:0] status_flags,
	input logic       unknown_command
);

	localparam logic [8:0] COL_LIMIT = 9'(COLUMNS);

	// a stalled result item stays
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result item dropped while stalled");

	a_hold_payload: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(ram_data) && $stable(status_flags))
		else $error("result payload changed while stalled");

	// no write means zeroed address and data fields
	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !ram_write |-> ram_page == 3'd0 && ram_column == 8'd0 && ram_data == 8'd0)
		else $error("address or data set without a ram write");

	// a write is a data item, its column in range and never flagged unknown
	a_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && ram_write |-> !unknown_command && ({1'b0, ram_column} < COL_LIMIT))
		else $error("bad ram write result");

endmodule

bind lcd_controller_command_decoder lcdcd_checker #(.COLUMNS(COLUMNS)) u_checker (.*);
